// File: rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int INDEX_W    = 11;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
    localparam logic [CELL_W-1:0] BLANK_CELL = {ATTR_RESET, CH_SPACE};

    typedef enum logic [3:0] {
        S_INIT  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_SWEEP = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// File: rtl/text_console_writer_top.sv
`default_nettype none

// Text console over a ROWS x COLUMNS cell memory with a single write port and a
// registered read port. After reset the block holds busy high while it blanks
// the memory. A put command, an unused command or an out-of-range read is
// accepted and its result appears on the next cycle, so such items can be issued
// every cycle. A read in range passes through the S_READ state before its result
// appears, because the memory read port is registered. A clear, and a line feed
// on the last row that scrolls the screen, sweep every cell through the one write
// port before busy drops. Each result is shown for one cycle with done high and
// must be captured then; there is no way to stall it.
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [CMD_W-1:0]     command,
    input  wire logic [CHAR_W-1:0]    char_code,
    input  wire logic [INDEX_W-1:0]   cell_index,
    output logic                      done,
    output logic [CELL_W-1:0]         cell_value,
    output logic [ROW_OUT_W-1:0]      cursor_row,
    output logic [COL_OUT_W-1:0]      cursor_column,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [ATTR_W-1:0]    cfg_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   sweep_reg, sweep_next;
    logic                move_reg, move_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                pend_move_reg, pend_move_next;
    logic [CELL_W-1:0]   fill_reg, fill_next;
    logic [ATTR_W-1:0]   attr_reg, attr_next;
    logic                done_reg, done_next;
    logic [CELL_W-1:0]   cell_value_reg, cell_value_next;
    logic [CELL_W-1:0]   rd_data_reg;

    logic [CELL_W-1:0]   mem [CELL_COUNT];

    logic                accept;
    logic                put_wr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CELL_W-1:0]   wr_data;
    logic [ADDR_W:0]     src_sum;
    logic                sweep_move;
    logic [31:0]         index_wide;
    logic                index_ok;
    logic                last_row;
    logic                last_col;
    logic [31:0]         row_wide;
    logic [31:0]         col_wide;

    assign busy       = (state_reg != S_IDLE) || pend_valid_reg;
    assign accept     = start && !busy;
    assign cfg_ready  = 1'b1;
    assign index_wide = 32'(cell_index);
    assign index_ok   = index_wide < 32'(CELL_COUNT);
    assign last_row   = row_reg == ROW_W'(ROWS - 1);
    assign last_col   = col_reg == COL_W'(COLUMNS - 1);
    assign src_sum    = {1'b0, sweep_reg} + (ADDR_W + 1)'(COLUMNS);
    assign sweep_move = move_reg && (sweep_reg < ADDR_W'(MOVE_COUNT));

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        sweep_next      = sweep_reg;
        move_next       = move_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_move_next  = pend_move_reg;
        fill_next       = fill_reg;
        attr_next       = cfg_valid ? cfg_data : attr_reg;
        done_next       = 1'b0;
        cell_value_next = cell_value_reg;
        put_wr          = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = index_wide[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = base_reg + ADDR_W'(col_reg);
        wr_data         = {attr_reg, char_code};

        case (state_reg)
            S_INIT, S_SWEEP:
            begin
                pend_valid_next = 1'b1;
                pend_addr_next  = sweep_reg;
                pend_move_next  = sweep_move;
                rd_en           = sweep_move;
                rd_addr         = src_sum[ADDR_W-1:0];
                if (sweep_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                    done_next  = (state_reg == S_SWEEP);
                end
                else
                begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            S_READ:
            begin
                cell_value_next = rd_data_reg;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cell_value_next = '0;
                    case (command)
                        CMD_PUT:
                        begin
                            if (char_code == CH_CR)
                            begin
                                col_next  = '0;
                                done_next = 1'b1;
                            end
                            else if (char_code == CH_LF)
                            begin
                                col_next = '0;
                                if (last_row)
                                begin
                                    state_next = S_SWEEP;
                                    move_next  = 1'b1;
                                    sweep_next = '0;
                                    fill_next  = {attr_reg, CH_SPACE};
                                end
                                else
                                begin
                                    row_next  = row_reg + ROW_W'(1);
                                    base_next = base_reg + ADDR_W'(COLUMNS);
                                    done_next = 1'b1;
                                end
                            end
                            else
                            begin
                                put_wr    = 1'b1;
                                done_next = 1'b1;
                                if (last_col)
                                begin
                                    col_next = '0;
                                    if (last_row)
                                    begin
                                        row_next  = '0;
                                        base_next = '0;
                                    end
                                    else
                                    begin
                                        row_next  = row_reg + ROW_W'(1);
                                        base_next = base_reg + ADDR_W'(COLUMNS);
                                    end
                                end
                                else
                                begin
                                    col_next = col_reg + COL_W'(1);
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            if (index_ok)
                            begin
                                rd_en      = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            base_next  = '0;
                            state_next = S_SWEEP;
                            move_next  = 1'b0;
                            sweep_next = '0;
                            fill_next  = {attr_reg, CH_SPACE};
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pend_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = pend_move_reg ? rd_data_reg : fill_reg;
        end
        else if (put_wr)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            row_reg        <= '0;
            col_reg        <= '0;
            base_reg       <= '0;
            sweep_reg      <= '0;
            move_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_move_reg  <= 1'b0;
            fill_reg       <= BLANK_CELL;
            attr_reg       <= ATTR_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            base_reg       <= base_next;
            sweep_reg      <= sweep_next;
            move_reg       <= move_next;
            pend_valid_reg <= pend_valid_next;
            pend_move_reg  <= pend_move_next;
            fill_reg       <= fill_next;
            attr_reg       <= attr_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= pend_addr_next;
        cell_value_reg <= cell_value_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign row_wide      = 32'(row_reg);
    assign col_wide      = 32'(col_reg);
    assign done          = done_reg;
    assign cell_value    = cell_value_reg;
    assign cursor_row    = row_wide[ROW_OUT_W-1:0];
    assign cursor_column = col_wide[COL_OUT_W-1:0];

    // A character write must never collide with a pending sweep write.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_valid_reg && put_wr))
        else $error("character write overlaps sweep write");

    // An item is only accepted once the sweep pipeline has drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == S_IDLE) && !pend_valid_reg)
        else $error("item accepted while memory is in use");

    // A read in range always reports in the cycle after its S_READ state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> done_reg)
        else $error("read result missing");

    // The power-up clearing pass reports nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |=> !done_reg)
        else $error("result reported during power-up clear");

    // The cursor stays on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= ROW_W'(ROWS - 1)) && (col_reg <= COL_W'(COLUMNS - 1)))
        else $error("cursor out of range");

endmodule

`default_nettype wire
